/* src/lmd_pkg.sv */
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared constants for the 3x3 local maximum detector: parameter defaults,
// configuration register indexes and port widths.
// ----------------------------------------------------------------------------
package lmd_pkg;

    // parameter defaults
    localparam int MAX_SIZE_DEF    = 32;
    localparam int VALUE_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_ADDR_W-1:0] REG_MATRIX_SIZE  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_COMPARE_MODE = CFG_ADDR_W'(1);

    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = CFG_DATA_W'(32);
    localparam logic [CFG_DATA_W-1:0] SIZE_MIN   = CFG_DATA_W'(2);

    // compare modes
    localparam logic MODE_STRICT = 1'b0;
    localparam logic MODE_GE     = 1'b1;

endpackage

/* src/lmd_ram.sv */
// ----------------------------------------------------------------------------
// lmd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/local_maximum_3x3_detector_unit.sv */
// ----------------------------------------------------------------------------
// local_maximum_3x3_detector_unit
// 3x3 non-maximum suppression over a square matrix streamed in raster order.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                 Contents
//  s_axis    in   s_axis_tvalid/tready      tdata: pixel_value
//  m_axis    out  m_axis_tvalid/tready      tdata: max_row, max_col, max_value
//                                           tlast: last_of_run
//  cfg       in   cfg_we (no wait)          cfg_addr: register, cfg_data: value
//
//  Steps: an item is accepted, the line store is read, one shared 8-neighbour
//  comparator bank then steps over the four possible candidates in turn, and
//  the maxima that the item decides (0 to 4) are then emitted one after
//  another, or the item ends with an idle check when there are none.
//  Reset clears counters, control and the configuration registers; the line
//  store and window hold no reset and are only used once written in the frame.
//  A stalled output keeps its item in the output register; the next input item
//  is accepted as soon as the last result has been loaded there.
//
module local_maximum_3x3_detector_unit #(
    parameter int MAX_SIZE    = lmd_pkg::MAX_SIZE_DEF,
    parameter int VALUE_WIDTH = lmd_pkg::VALUE_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,

    // pixel_value
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,

    // max_row, max_col, max_value (lowest bit up)
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((2*$clog2(MAX_SIZE)+VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                                 m_axis_tlast,

    input  logic                                 cfg_we,
    input  logic [lmd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [lmd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int IDX_W   = $clog2(MAX_SIZE);
    localparam int VW      = VALUE_WIDTH;
    localparam int OUT_W   = ((2*IDX_W+VALUE_WIDTH+7)/8)*8;
    localparam int CW      = lmd_pkg::CFG_DATA_W;

    // control states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [CW-1:0] size_reg;
    logic          mode_reg;
    logic          size_write;

    assign size_write = cfg_we && (cfg_addr == lmd_pkg::REG_MATRIX_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= lmd_pkg::SIZE_RESET;
            mode_reg <= lmd_pkg::MODE_STRICT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                lmd_pkg::REG_MATRIX_SIZE:  size_reg <= cfg_data;
                lmd_pkg::REG_COMPARE_MODE: mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // side length clamped to [2, MAX_SIZE]
    logic [CW-1:0] n_eff;

    always_comb
    begin
        priority if (size_reg < lmd_pkg::SIZE_MIN)
            n_eff = lmd_pkg::SIZE_MIN;
        else if (size_reg > CW'(MAX_SIZE))
            n_eff = CW'(MAX_SIZE);
        else
            n_eff = size_reg;
    end

    // ------------------------------------------------------------------
    // raster position
    // ------------------------------------------------------------------
    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] row_cnt_reg, col_cnt_reg;
    logic [IDX_W-1:0] r_cur, c_cur;
    logic             last_row_cur, last_col_cur;
    logic             in_take;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign r_cur        = (CW'(row_cnt_reg) >= n_eff) ? '0 : row_cnt_reg;
    assign c_cur        = (CW'(col_cnt_reg) >= n_eff) ? '0 : col_cnt_reg;
    assign last_row_cur = (CW'(r_cur) == n_eff - CW'(1));
    assign last_col_cur = (CW'(c_cur) == n_eff - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (size_write)
        begin
            // new size restarts the frame
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (in_take)
        begin
            if (last_col_cur)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row_cur ? '0 : r_cur + IDX_W'(1);
            end
            else
            begin
                col_cnt_reg <= c_cur + IDX_W'(1);
                row_cnt_reg <= r_cur;
            end
        end
    end

    // per-item payload, captured at accept
    logic signed [VW-1:0] pix_reg;
    logic [IDX_W-1:0]     r_reg, c_reg;
    logic                 last_row_reg, last_col_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pix_reg      <= s_axis_tdata[VW-1:0];
            r_reg        <= r_cur;
            c_reg        <= c_cur;
            last_row_reg <= last_row_cur;
            last_col_reg <= last_col_cur;
        end
    end

    // ------------------------------------------------------------------
    // line store: entry c = {row r-1, row r-2} at column c.
    // Read at accept, written back in ST_READ; one item in flight, so a
    // read never meets a pending write to the same column.
    // ------------------------------------------------------------------
    logic [2*VW-1:0] ram_rdata;
    logic [2*VW-1:0] ram_wdata;
    logic            ram_we;

    assign ram_we    = (state_reg == ST_READ);
    assign ram_wdata = {pix_reg, ram_rdata[2*VW-1:VW]};

    lmd_ram #(
        .WIDTH (2*VW),
        .DEPTH (MAX_SIZE)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_reg),
        .wdata (ram_wdata),
        .re    (in_take),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // 3x3 window: rows r-2..r, columns c-2..c
    // ------------------------------------------------------------------
    logic signed [VW-1:0] win_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= ram_rdata[VW-1:0];
            win_reg[1][2] <= ram_rdata[2*VW-1:VW];
            win_reg[2][2] <= pix_reg;
        end
    end

    // which window rows / columns lie inside the matrix
    logic [2:0] row_ok, col_ok;

    assign row_ok = {1'b1, (r_reg != '0), (r_reg > IDX_W'(1))};
    assign col_ok = {1'b1, (c_reg != '0), (c_reg > IDX_W'(1))};

    // ------------------------------------------------------------------
    // candidates, bit k: row r-1+k[1], column c-1+k[0]
    // bit 0 (r-1,c-1); bit 1 (r-1,c) on last column;
    // bit 2 (r,c-1) on last row; bit 3 (r,c) at frame end
    // ------------------------------------------------------------------
    logic [3:0] cand_reg;
    logic [3:0] hit_reg;
    logic [1:0] eval_idx_reg;

    // shared comparator bank for candidate eval_idx_reg
    logic [1:0]           cr, cc;
    logic [2:0]           nr, nc;
    logic signed [VW-1:0] centre;
    logic                 beats_all;

    always_comb
    begin
        cr        = eval_idx_reg[1] ? 2'd2 : 2'd1;
        cc        = eval_idx_reg[0] ? 2'd2 : 2'd1;
        centre    = win_reg[cr][cc];
        beats_all = 1'b1;
        nr        = '0;
        nc        = '0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                nr = 3'(cr) + 3'(dr) - 3'd1;
                nc = 3'(cc) + 3'(dc) - 3'd1;
                if (!(dr == 1 && dc == 1) && (nr <= 3'd2) && (nc <= 3'd2)
                    && row_ok[nr[1:0]] && col_ok[nc[1:0]])
                begin
                    if (mode_reg == lmd_pkg::MODE_GE)
                    begin
                        if (centre < win_reg[nr[1:0]][nc[1:0]])
                            beats_all = 1'b0;
                    end
                    else
                    begin
                        if (centre <= win_reg[nr[1:0]][nc[1:0]])
                            beats_all = 1'b0;
                    end
                end
            end
        end
    end

    // lowest pending hit goes out first (raster order)
    logic [1:0] sel;
    logic [3:0] hit_rest;
    logic       out_free;

    always_comb
    begin
        sel = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (hit_reg[i])
                sel = 2'(i);
        end
        hit_rest = hit_reg & ~(4'b0001 << sel);
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_row_reg, out_col_reg;
    logic signed [VW-1:0] out_value_reg;
    logic                 out_last_reg;
    logic                 out_load;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (state_reg == ST_EMIT) && (hit_reg != '0) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= sel[1] ? r_reg : r_reg - IDX_W'(1);
            out_col_reg   <= sel[0] ? c_reg : c_reg - IDX_W'(1);
            out_value_reg <= win_reg[sel[1] ? 2'd2 : 2'd1][sel[0] ? 2'd2 : 2'd1];
            out_last_reg  <= (hit_rest == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_value_reg, out_col_reg, out_row_reg});
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_READ;
            ST_READ: state_next = ST_EVAL;
            ST_EVAL: if (eval_idx_reg == 2'd3) state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (hit_reg == '0)
                    state_next = ST_IDLE;
                else if (out_free && (hit_rest == '0))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cand_reg     <= '0;
            hit_reg      <= '0;
            eval_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_READ:
                begin
                    cand_reg <= {last_row_reg && last_col_reg,
                                 last_row_reg && (c_reg != '0),
                                 (r_reg != '0) && last_col_reg,
                                 (r_reg != '0) && (c_reg != '0)};
                    hit_reg      <= '0;
                    eval_idx_reg <= '0;
                end
                ST_EVAL:
                begin
                    hit_reg[eval_idx_reg] <= cand_reg[eval_idx_reg] && beats_all;
                    eval_idx_reg          <= eval_idx_reg + 2'd1;
                end
                ST_EMIT:
                begin
                    if (out_load)
                        hit_reg <= hit_rest;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // an accepted item always goes to the line store read next
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_READ))
        else $error("accepted item did not start a line store read");

    // evaluation always starts from the first candidate
    a_read_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_EVAL) && (eval_idx_reg == 2'd0))
        else $error("evaluation did not start at candidate zero");

    // only real candidates can be reported
    a_hit_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((hit_reg & ~cand_reg) == 4'd0))
        else $error("hit on a position that is not a candidate");

    // raster position stays inside the matrix
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(row_cnt_reg) < n_eff) && (CW'(col_cnt_reg) < n_eff))
        else $error("raster counters outside the matrix");

    // loading the last result returns the sequencer to idle
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (hit_rest == 4'd0)) |=> (state_reg == ST_IDLE))
        else $error("last result loaded but sequencer did not return to idle");
`endif

endmodule
